// File: design/midi_event_gate_generator_assert.svh
// Assertion macros shared by the checker of the MIDI event gate generator.
`ifndef MIDI_EVENT_GATE_GENERATOR_ASSERT_SVH
`define MIDI_EVENT_GATE_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after reset is seen.
`define MEG_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// File: design/meg_pkg.sv
// Package of the MIDI event gate generator: widths, codes, interval table and helpers.
package meg_pkg;

   localparam int GATES_DEF          = 8;
   localparam int INTERVAL_ITEMS_DEF = 30;
   localparam int MAX_GATES          = 8;
   localparam int TABLE_SIZE         = 30;
   localparam int TICKS_PER_BEAT     = 24;

   localparam int MODE_W     = 2;
   localparam int CHAN_W     = 5;
   localparam int NOTE_W     = 7;
   localparam int DRAW_W     = 7;
   localparam int DRAWS_W    = MAX_GATES * DRAW_W;
   localparam int INDEX_W    = 5;
   localparam int CHOICES_W  = MAX_GATES * INDEX_W;
   localparam int THRESH_W   = 7;
   localparam int TICK_W     = 5;
   localparam int BEAT_W     = 2;
   localparam int LANE_W     = 3;
   localparam int SKIP_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam int RECIP_SHIFT = 12;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int GATE_NUM_W  = 4;
   localparam int PROD_W      = NOTE_W + RECIP_W;
   localparam int BACK_W      = NOTE_W + GATE_NUM_W;

   localparam logic [TICK_W-1:0] LAST_TICK = TICK_W'(TICKS_PER_BEAT - 1);

   typedef enum logic [MODE_W-1:0] {
      EV_NOTE_ON  = 2'd0,
      EV_NOTE_OFF = 2'd1,
      EV_CLOCK    = 2'd2,
      EV_START    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      OP_NOTE    = 2'd0,
      OP_CHANNEL = 2'd1,
      OP_CLOCK   = 2'd2,
      OP_OFF     = 2'd3
   } op_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OP_MODE      = 2'd0,
      CSR_NOTE_CHANNEL = 2'd1,
      CSR_INTERVALS    = 2'd2,
      CSR_THRESHOLD    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      DIV_24 = 3'd0,
      DIV_12 = 3'd1,
      DIV_8  = 3'd2,
      DIV_6  = 3'd3,
      DIV_4  = 3'd4,
      DIV_3  = 3'd5
   } div_type;

   typedef struct packed {
      div_type           div;
      logic [SKIP_W-1:0] skip;
   } interval_type;

   typedef struct packed {
      op_mode_type          op_mode;
      logic [CHAN_W-1:0]    note_channel;
      logic [CHOICES_W-1:0] interval_choices;
      logic [THRESH_W-1:0]  fire_threshold;
   } cfg_type;

   localparam logic [CHOICES_W-1:0] CHOICES_RESET = 40'd176196467078;

   localparam interval_type INTERVAL_TABLE [TABLE_SIZE] = '{
      '{DIV_24, 3'd0}, '{DIV_12, 3'd0}, '{DIV_6, 3'd0},
      '{DIV_3, 3'd0},  '{DIV_8, 3'd0},  '{DIV_4, 3'd0},
      '{DIV_24, 3'd1}, '{DIV_12, 3'd1}, '{DIV_6, 3'd1},
      '{DIV_3, 3'd1},  '{DIV_8, 3'd1},  '{DIV_4, 3'd1},
      '{DIV_24, 3'd2}, '{DIV_12, 3'd2}, '{DIV_6, 3'd2},
      '{DIV_3, 3'd2},  '{DIV_8, 3'd2},  '{DIV_4, 3'd2},
      '{DIV_24, 3'd3}, '{DIV_12, 3'd3}, '{DIV_6, 3'd3},
      '{DIV_3, 3'd3},  '{DIV_8, 3'd3},  '{DIV_4, 3'd3},
      '{DIV_24, 3'd4}, '{DIV_12, 3'd4}, '{DIV_6, 3'd4},
      '{DIV_3, 3'd4},  '{DIV_8, 3'd4},  '{DIV_4, 3'd4}
   };

   // Bit t of each mask is set when tick t is a multiple of the division.
   localparam logic [31:0] HIT_24 = 32'h0000_0001;
   localparam logic [31:0] HIT_12 = 32'h0000_1001;
   localparam logic [31:0] HIT_8  = 32'h0001_0101;
   localparam logic [31:0] HIT_6  = 32'h0004_1041;
   localparam logic [31:0] HIT_4  = 32'h0011_1111;
   localparam logic [31:0] HIT_3  = 32'h0024_9249;

   function automatic logic tick_hit(input div_type div, input logic [TICK_W-1:0] tick);
      logic hit;
      unique case (div)
         DIV_24:  hit = HIT_24[tick];
         DIV_12:  hit = HIT_12[tick];
         DIV_8:   hit = HIT_8[tick];
         DIV_6:   hit = HIT_6[tick];
         DIV_4:   hit = HIT_4[tick];
         DIV_3:   hit = HIT_3[tick];
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Beat count modulo skip is zero; a skip of zero is handled by the draw.
   function automatic logic beat_hit(input logic [SKIP_W-1:0] skip,
                                     input logic [BEAT_W-1:0] beat);
      logic hit;
      unique case (skip)
         3'd1:    hit = 1'b1;
         3'd2:    hit = ~beat[0];
         3'd3:    hit = (beat == 2'd0) || (beat == 2'd3);
         3'd4:    hit = (beat == 2'd0);
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Note number modulo the gate count. The quotient comes from a multiply by
   // the rounded-up reciprocal, which is exact for every 7-bit note.
   function automatic logic [LANE_W-1:0] note_lane(input logic [NOTE_W-1:0]     note,
                                                   input logic [RECIP_W-1:0]    recip,
                                                   input logic [GATE_NUM_W-1:0] gates);
      logic [PROD_W-1:0] product;
      logic [NOTE_W-1:0] quot;
      logic [BACK_W-1:0] back;
      logic [BACK_W-1:0] rem;
      product = PROD_W'(note) * PROD_W'(recip);
      quot    = product[RECIP_SHIFT +: NOTE_W];
      back    = BACK_W'(quot) * BACK_W'(gates);
      rem     = BACK_W'(note) - back;
      return rem[LANE_W-1:0];
   endfunction

endpackage

// File: design/meg_csr.sv
// Configuration registers of the MIDI event gate generator.
module meg_csr
   import meg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output logic                  mode_write
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in     = cfg_ff;
      mode_write = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OP_MODE: begin
               cfg_in.op_mode = op_mode_type'(csr_wdata[1:0]);
               mode_write     = 1'b1;
            end
            CSR_NOTE_CHANNEL: cfg_in.note_channel     = csr_wdata[CHAN_W-1:0];
            CSR_INTERVALS:    cfg_in.interval_choices = csr_wdata[CHOICES_W-1:0];
            CSR_THRESHOLD:    cfg_in.fire_threshold   = csr_wdata[THRESH_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_mode          <= OP_CHANNEL;
         cfg_ff.note_channel     <= 5'd10;
         cfg_ff.interval_choices <= CHOICES_RESET;
         cfg_ff.fire_threshold   <= 7'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/meg_clock_div.sv
// Per-gate clock divider lanes: next gate levels on a MIDI clock event.
module meg_clock_div
   import meg_pkg::*;
#(
   parameter int GATES          = GATES_DEF,
   parameter int INTERVAL_ITEMS = INTERVAL_ITEMS_DEF
) (
   input  logic [CHOICES_W-1:0] interval_choices,
   input  logic [THRESH_W-1:0]  fire_threshold,
   input  logic [DRAWS_W-1:0]   random_draws,
   input  logic [TICK_W-1:0]    tick,
   input  logic [BEAT_W-1:0]    beat,
   input  logic [GATES-1:0]     gates_now,
   output logic [GATES-1:0]     gates_next
);

   localparam int ITEMS_EFF = (INTERVAL_ITEMS < TABLE_SIZE) ?
                              ((INTERVAL_ITEMS < 1) ? 1 : INTERVAL_ITEMS) : TABLE_SIZE;
   localparam logic [INDEX_W-1:0] ITEMS_LIMIT = INDEX_W'(ITEMS_EFF);
   localparam logic [INDEX_W-1:0] LAST_INDEX  = INDEX_W'(ITEMS_EFF - 1);

   for (genvar g = 0; g < GATES; g++) begin : g_lane
      logic [INDEX_W-1:0] raw_index;
      logic [INDEX_W-1:0] index;
      interval_type       entry;
      logic [DRAW_W-1:0]  draw;
      logic               fire;

      always_comb begin
         raw_index = interval_choices[INDEX_W*g +: INDEX_W];
         index     = (raw_index >= ITEMS_LIMIT) ? LAST_INDEX : raw_index;
         entry     = INTERVAL_TABLE[index];
         draw      = random_draws[DRAW_W*g +: DRAW_W];
         if (entry.skip == '0) begin
            fire = (draw < fire_threshold);
         end else begin
            fire = beat_hit(entry.skip, beat);
         end
         // Off the division the gate drops; on it, a miss keeps the old level.
         if (tick_hit(entry.div, tick)) begin
            gates_next[g] = gates_now[g] | fire;
         end else begin
            gates_next[g] = 1'b0;
         end
      end
   end

endmodule

// File: design/meg_core.sv
// Event decode, gate and tick state, and the result register.
module meg_core
   import meg_pkg::*;
#(
   parameter int GATES          = GATES_DEF,
   parameter int INTERVAL_ITEMS = INTERVAL_ITEMS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 mode_write,
   input  logic                 in_valid,
   input  logic [MODE_W-1:0]    in_mode,
   input  logic [CHAN_W-1:0]    in_channel,
   input  logic [NOTE_W-1:0]    in_note,
   input  logic [DRAWS_W-1:0]   in_random_draws,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [MAX_GATES-1:0] rsp_gate_levels
);

   localparam logic [CHAN_W-1:0]     CHAN_FIRST = CHAN_W'(GATES + 1);
   localparam logic [CHAN_W-1:0]     CHAN_LIMIT = CHAN_W'(2 * GATES + 1);
   localparam logic [RECIP_W-1:0]    NOTE_RECIP = RECIP_W'((RECIP_ONE + GATES - 1) / GATES);
   localparam logic [GATE_NUM_W-1:0] GATE_NUM   = GATE_NUM_W'(GATES);

   logic [GATES-1:0]     gate_bits_ff, gate_bits_in;
   logic [TICK_W-1:0]    tick_ff, tick_in;
   logic [BEAT_W-1:0]    beat_ff, beat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MAX_GATES-1:0] rsp_levels_ff, rsp_levels_in;

   logic                 advance;
   logic                 note_hit;
   logic [LANE_W-1:0]    note_lane_sel;
   logic [CHAN_W-1:0]    chan_offset;
   logic [GATES-1:0]     note_bit;
   logic [GATES-1:0]     clock_gates;
   logic                 clock_active;

   meg_clock_div #(
      .GATES          (GATES),
      .INTERVAL_ITEMS (INTERVAL_ITEMS)
   ) u_clock_div (
      .interval_choices (cfg.interval_choices),
      .fire_threshold   (cfg.fire_threshold),
      .random_draws     (in_random_draws),
      .tick             (tick_ff),
      .beat             (beat_ff),
      .gates_now        (gate_bits_ff),
      .gates_next       (clock_gates)
   );

   assign out_free     = ~rsp_valid_ff | rsp_ready;
   assign advance      = in_valid & out_free;
   assign clock_active = (cfg.op_mode == OP_CLOCK);
   assign chan_offset  = in_channel - CHAN_FIRST;

   // Which gate a note event addresses, if any.
   always_comb begin
      note_hit      = 1'b0;
      note_lane_sel = '0;
      unique case (cfg.op_mode)
         OP_NOTE: begin
            note_hit      = (in_channel == cfg.note_channel);
            note_lane_sel = note_lane(in_note, NOTE_RECIP, GATE_NUM);
         end
         OP_CHANNEL: begin
            note_hit      = (in_channel >= CHAN_FIRST) && (in_channel < CHAN_LIMIT);
            note_lane_sel = chan_offset[LANE_W-1:0];
         end
         default: begin
            note_hit      = 1'b0;
            note_lane_sel = '0;
         end
      endcase
      for (int g = 0; g < GATES; g++) begin
         note_bit[g] = note_hit && (note_lane_sel == LANE_W'(g));
      end
   end

   always_comb begin
      gate_bits_in  = gate_bits_ff;
      tick_in       = tick_ff;
      beat_in       = beat_ff;
      rsp_levels_in = rsp_levels_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      if (advance) begin
         unique case (event_type'(in_mode))
            EV_NOTE_ON:  gate_bits_in = gate_bits_ff | note_bit;
            EV_NOTE_OFF: gate_bits_in = gate_bits_ff & ~note_bit;
            EV_CLOCK: begin
               if (clock_active) begin
                  gate_bits_in = clock_gates;
                  if (tick_ff == LAST_TICK) begin
                     tick_in = '0;
                     beat_in = beat_ff + 2'd1;
                  end else begin
                     tick_in = tick_ff + 5'd1;
                  end
               end
            end
            EV_START:    tick_in = '0;
            default:     gate_bits_in = gate_bits_ff;
         endcase
         rsp_levels_in = MAX_GATES'(gate_bits_in);
         rsp_valid_in  = 1'b1;
      end else if (mode_write) begin
         gate_bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_bits_ff <= '0;
         tick_ff      <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gate_bits_ff <= gate_bits_in;
         tick_ff      <= tick_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_levels_ff <= rsp_levels_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gate_levels = rsp_levels_ff;

endmodule

// File: design/midi_event_gate_generator.sv
// Top level of the MIDI event gate generator: input register, config and gate core.
//
//   Channel   Ports                                    Flow
//   req       req_valid/req_ready, mode..random_draws  MIDI event in
//   rsp       rsp_valid/rsp_ready, rsp_gate_levels     gate levels out
//   csr       csr_we, csr_index, csr_wdata             register write, no wait
//
// An item waits in the input register and moves on to the result register when
// the result side is free: one item per cycle sustained while rsp_ready holds.
// The single gate state update between the two registers sets the rate.
// Reset is synchronous: gates low, tick and beat counts zero, both registers empty.
// A stalled result holds; req_ready stays high while the result side can move.
module midi_event_gate_generator
   import meg_pkg::*;
#(
   parameter int GATES          = GATES_DEF,
   parameter int INTERVAL_ITEMS = INTERVAL_ITEMS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [NOTE_W-1:0]     req_note,
   input  logic [DRAWS_W-1:0]    req_random_draws,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MAX_GATES-1:0]  rsp_gate_levels,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   logic    mode_write;
   logic    out_free;

   logic                in_valid_ff, in_valid_in;
   logic [MODE_W-1:0]   in_mode_ff;
   logic [CHAN_W-1:0]   in_channel_ff;
   logic [NOTE_W-1:0]   in_note_ff;
   logic [DRAWS_W-1:0]  in_draws_ff;
   logic                take;

   meg_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .mode_write (mode_write)
   );

   // The input register refills in the same cycle its item moves on.
   assign req_ready   = ~in_valid_ff | out_free;
   assign take        = req_valid & req_ready;
   assign in_valid_in = take | (in_valid_ff & ~out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_mode_ff    <= req_mode;
         in_channel_ff <= req_channel;
         in_note_ff    <= req_note;
         in_draws_ff   <= req_random_draws;
      end
   end

   meg_core #(
      .GATES          (GATES),
      .INTERVAL_ITEMS (INTERVAL_ITEMS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .mode_write      (mode_write),
      .in_valid        (in_valid_ff),
      .in_mode         (in_mode_ff),
      .in_channel      (in_channel_ff),
      .in_note         (in_note_ff),
      .in_random_draws (in_draws_ff),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_gate_levels (rsp_gate_levels)
   );

endmodule

// File: design/meg_checker.sv
// Port-level checker of the MIDI event gate generator and its bind.
`include "midi_event_gate_generator_assert.svh"

module meg_checker
   import meg_pkg::*;
#(
   parameter int GATES = GATES_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [MAX_GATES-1:0] rsp_gate_levels
);

   `MEG_ASSERT_RESET(a_reset_empty, !rsp_valid, "result valid right after reset")
   `MEG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gate_levels), "stalled result changed")
   `MEG_ASSERT_NOW(a_ready_when_free, rsp_ready || !rsp_valid, req_ready, "input stalled while output side free")
   `MEG_ASSERT_NEXT(a_latency, (req_valid && req_ready) ##1 rsp_ready, rsp_valid, "accepted item produced no result")
   `MEG_ASSERT_NOW(a_unused_gates_low, rsp_valid, (rsp_gate_levels >> GATES) == '0, "gate beyond count is high")

endmodule

bind midi_event_gate_generator meg_checker #(
   .GATES (GATES)
) u_meg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_gate_levels (rsp_gate_levels)
);
